/* sv/rlim_pkg.sv */
// ============================================================================
// rlim_pkg
// Shared types and register indexes for the per-client message rate limiter.
// ============================================================================
`default_nettype none

package rlim_pkg;

  typedef logic [7:0]  client_t;
  typedef logic [62:0] ts_t;
  typedef logic [15:0] count_t;
  typedef logic [15:0] max_t;
  typedef logic [47:0] win_t;
  typedef logic [1:0]  cfg_idx_t;
  typedef logic [47:0] cfg_data_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_MAX_MESSAGES = 2'd0;
  localparam cfg_idx_t CFG_WINDOW_LEN   = 2'd1;
  localparam cfg_idx_t CFG_WINDOW_MODE  = 2'd2;

  // Window modes.
  localparam logic MODE_FIXED   = 1'b0;
  localparam logic MODE_SLIDING = 1'b1;

endpackage

`default_nettype wire

/* sv/rlim_if.sv */
// ============================================================================
// rlim_if
// Valid/ready channels of the rate limiter: messages, results, config writes.
// ============================================================================
`default_nettype none

interface rlim_msg_if;
  import rlim_pkg::*;
  logic    valid;
  logic    ready;
  client_t client_index;
  ts_t     now_ns;
  modport source (output valid, output client_index, output now_ns, input ready);
  modport sink   (input valid, input client_index, input now_ns, output ready);
endinterface

interface rlim_res_if;
  import rlim_pkg::*;
  logic   valid;
  logic   ready;
  logic   allowed;
  count_t observed_count;
  logic   log_overflow;
  modport source (output valid, output allowed, output observed_count,
                  output log_overflow, input ready);
  modport sink   (input valid, input allowed, input observed_count,
                  input log_overflow, output ready);
endinterface

interface rlim_cfg_if;
  import rlim_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/rlim_ram.sv */
// ============================================================================
// rlim_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
`default_nettype none

module rlim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/per_client_message_rate_limiter_unit.sv */
// ============================================================================
// per_client_message_rate_limiter_unit
// Per-client message rate limiter with fixed-window and sliding-window modes.
// ============================================================================
// Sequence: with limiting off an accepted item goes straight to S_PUT; in fixed
//   mode it first reads the client table in S_META, and in sliding mode it then
//   also passes S_CHK, with one client-log RAM read per expired timestamp dropped.
// Items: a new item is accepted only after the previous one has left S_PUT.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every entry
//   of the client table RAM, during which no item is accepted.
`default_nettype none

module per_client_message_rate_limiter_unit #(
  parameter int CLIENTS   = 256,
  parameter int LOG_DEPTH = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  rlim_msg_if.sink   in_ch,
  rlim_res_if.source out_ch,
  rlim_cfg_if.sink   cfg_ch
);

  import rlim_pkg::*;

  // Client address width and log slot width.
  localparam int CAW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int LW  = $clog2(LOG_DEPTH);
  localparam int LOG_RAM_DEPTH = 2 ** (CAW + LW);

  localparam logic [LW:0]    DEPTH_C   = (LW + 1)'(LOG_DEPTH);
  localparam logic [LW-1:0]  LAST_SLOT = LW'(LOG_DEPTH - 1);
  localparam logic [CAW-1:0] LAST_CLI  = CAW'(CLIENTS - 1);

  // Sequencer state codes.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_META  = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;

  // One client table entry holds both the fixed-window state and the
  // sliding-log ring pointers, so one RAM access covers either mode.
  typedef struct packed {
    ts_t         start;
    count_t      count;
    logic        active;
    logic [LW-1:0] head;
    logic [LW:0]   fill;
  } meta_t;

  // Signed age test: a negative age never counts as expired.
  function automatic logic age_expired(input ts_t now, input ts_t then_ts, input win_t win);
    logic [63:0] d;
    d = {1'b0, now} - {1'b0, then_ts};
    return !d[63] && (d[62:0] >= {15'd0, win});
  endfunction

  // Configuration registers.
  max_t max_r, max_nxt;
  win_t win_r, win_nxt;
  logic mode_r, mode_nxt;

  // Sequencer and per-item registers.
  logic [2:0]     state_r, state_nxt;
  logic [CAW-1:0] clr_r, clr_nxt;
  logic [CAW-1:0] client_r, client_nxt;
  ts_t            now_r, now_nxt;
  meta_t          meta_r, meta_nxt;
  logic [LW-1:0]  head_r, head_nxt;
  logic [LW:0]    fill_r, fill_nxt;
  logic           res_allowed_r, res_allowed_nxt;
  count_t         res_count_r, res_count_nxt;
  logic           res_ovf_r, res_ovf_nxt;

  // Output register.
  logic   out_valid_r, out_valid_nxt;
  logic   out_allowed_r, out_allowed_nxt;
  count_t out_count_r, out_count_nxt;
  logic   out_ovf_r, out_ovf_nxt;

  // Client table RAM.
  logic           meta_we, meta_re;
  logic [CAW-1:0] meta_waddr, meta_raddr;
  meta_t          meta_wdata, meta_rdata;

  // Sliding log RAM, addressed by client and slot.
  logic              log_we, log_re;
  logic [CAW+LW-1:0] log_waddr, log_raddr;
  ts_t               log_wdata, log_rdata;

  // Helpers.
  logic          in_acc;
  logic          in_range;
  logic          enabled;
  logic          fx_exp;
  count_t        fx_count;
  logic          lg_exp;
  logic [LW-1:0] head_inc;
  logic [LW:0]   tail_sum;
  logic [LW-1:0] tail;
  count_t        sl_count;
  logic          sl_full;

  rlim_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (CLIENTS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  rlim_ram #(
    .WIDTH ($bits(ts_t)),
    .DEPTH (LOG_RAM_DEPTH)
  ) u_log_ram (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_waddr),
    .wdata (log_wdata),
    .re    (log_re),
    .raddr (log_raddr),
    .rdata (log_rdata)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.allowed        = out_allowed_r;
  assign out_ch.observed_count = out_count_r;
  assign out_ch.log_overflow   = out_ovf_r;

  assign in_range = (32'(in_ch.client_index) < 32'(CLIENTS));
  assign enabled  = (max_r != '0) && (win_r != '0) && in_range;

  // Fixed window: restart on first use or when the window has run out; the
  // count saturates at its full range.
  assign fx_exp   = !meta_rdata.active || age_expired(now_r, meta_rdata.start, win_r);
  assign fx_count = fx_exp ? 16'd1 :
                    ((meta_rdata.count == 16'hFFFF) ? meta_rdata.count
                                                    : meta_rdata.count + 16'd1);

  // Sliding window: the front entry is tested while the ring is non-empty.
  assign lg_exp   = (fill_r != '0) && age_expired(now_r, log_rdata, win_r);
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign tail_sum = {1'b0, head_r} + fill_r;
  assign tail     = (tail_sum >= DEPTH_C) ? LW'(tail_sum - DEPTH_C) : tail_sum[LW-1:0];
  assign sl_count = 16'(fill_r) + 16'd1;
  assign sl_full  = (fill_r == DEPTH_C);

  always_comb begin
    max_nxt         = max_r;
    win_nxt         = win_r;
    mode_nxt        = mode_r;
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    client_nxt      = client_r;
    now_nxt         = now_r;
    meta_nxt        = meta_r;
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    res_allowed_nxt = res_allowed_r;
    res_count_nxt   = res_count_r;
    res_ovf_nxt     = res_ovf_r;
    out_valid_nxt   = out_valid_r;
    out_allowed_nxt = out_allowed_r;
    out_count_nxt   = out_count_r;
    out_ovf_nxt     = out_ovf_r;

    meta_we    = 1'b0;
    meta_waddr = client_r;
    meta_wdata = meta_r;
    meta_re    = 1'b0;
    meta_raddr = CAW'(in_ch.client_index);
    log_we     = 1'b0;
    log_waddr  = {client_r, tail};
    log_wdata  = now_r;
    log_re     = 1'b0;
    log_raddr  = {client_r, head_inc};

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MAX_MESSAGES: max_nxt  = cfg_ch.data[15:0];
        CFG_WINDOW_LEN:   win_nxt  = cfg_ch.data;
        CFG_WINDOW_MODE:  mode_nxt = cfg_ch.data[0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        // Zero one client table entry per cycle.
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        meta_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == LAST_CLI) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          client_nxt = CAW'(in_ch.client_index);
          now_nxt    = in_ch.now_ns;
          if (enabled) begin
            meta_re   = 1'b1;
            state_nxt = S_META;
          end else begin
            res_allowed_nxt = 1'b1;
            res_count_nxt   = '0;
            res_ovf_nxt     = 1'b0;
            state_nxt       = S_PUT;
          end
        end
      end
      S_META: begin
        meta_nxt = meta_rdata;
        if (mode_r == MODE_FIXED) begin
          meta_we    = 1'b1;
          meta_wdata = meta_rdata;
          meta_wdata.start  = fx_exp ? now_r : meta_rdata.start;
          meta_wdata.count  = fx_count;
          meta_wdata.active = 1'b1;
          res_allowed_nxt   = (fx_count <= max_r);
          res_count_nxt     = fx_count;
          res_ovf_nxt       = 1'b0;
          state_nxt         = S_PUT;
        end else begin
          // Fetch the front timestamp of this client's ring.
          head_nxt  = meta_rdata.head;
          fill_nxt  = meta_rdata.fill;
          log_re    = 1'b1;
          log_raddr = {client_r, meta_rdata.head};
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (lg_exp) begin
          // Drop the expired front entry and fetch the next one.
          head_nxt = head_inc;
          fill_nxt = fill_r - 1'b1;
          log_re   = 1'b1;
        end else begin
          // Push the new timestamp unless the ring is full; write back.
          log_we           = !sl_full;
          meta_we          = 1'b1;
          meta_wdata       = meta_r;
          meta_wdata.head  = head_r;
          meta_wdata.fill  = sl_full ? fill_r : fill_r + 1'b1;
          res_allowed_nxt  = (sl_count <= max_r);
          res_count_nxt    = sl_count;
          res_ovf_nxt      = sl_full;
          state_nxt        = S_PUT;
        end
      end
      S_PUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = res_allowed_r;
          out_count_nxt   = res_count_r;
          out_ovf_nxt     = res_ovf_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= '0;
      win_r       <= '0;
      mode_r      <= MODE_FIXED;
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      max_r       <= max_nxt;
      win_r       <= win_nxt;
      mode_r      <= mode_nxt;
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    client_r      <= client_nxt;
    now_r         <= now_nxt;
    meta_r        <= meta_nxt;
    head_r        <= head_nxt;
    fill_r        <= fill_nxt;
    res_allowed_r <= res_allowed_nxt;
    res_count_r   <= res_count_nxt;
    res_ovf_r     <= res_ovf_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_count_r   <= out_count_nxt;
    out_ovf_r     <= out_ovf_nxt;
  end

  // A ring never holds more than its depth while entries are being checked.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (fill_r <= DEPTH_C))
    else $error("sliding log fill exceeds its depth");

  // An accepted item always takes the sequencer out of idle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("item accepted without leaving idle");

  // An overflow result only comes from a completely full ring.
  a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (out_count_r == 16'(LOG_DEPTH) + 16'd1))
    else $error("overflow reported with a ring that is not full");

  // A rejected item has counted at least one message.
  a_reject_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_allowed_r) |-> (out_count_r != '0))
    else $error("reject reported with a zero count");

endmodule

`default_nettype wire
